// File: rtl/core/q15au_pkg.sv
// ----------------------------------------------------------------------------
// q15au_pkg: shared types and constants of the Q15 arithmetic unit
// Operation and status codes, Q15 limits, divider pipeline geometry and the
// records that travel down the pipeline beside each item.
// ----------------------------------------------------------------------------
package q15au_pkg;

  // operation codes
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_MUL = 2'd1;
  localparam logic [1:0] CMD_DIV = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  // Q15 limits
  localparam logic signed [15:0] Q15_MAX     = 16'sh7FFF;
  localparam logic signed [15:0] Q15_SYM_MIN = -16'sh7FFF;
  localparam logic signed [15:0] Q15_MIN     = 16'sh8000;
  localparam int Q15_FRAC = 15;

  // restoring divider: one quotient bit per step
  localparam int DIV_BITS        = Q15_FRAC;
  localparam int STEPS_PER_STAGE = 3;
  localparam int DIV_STAGES      = DIV_BITS / STEPS_PER_STAGE;

  // partial division state
  typedef struct packed {
    logic [15:0]         rem;   // running remainder, below dvsr on a divide not resolved early
    logic [DIV_BITS-1:0] quo;   // quotient magnitude bits so far
    logic [15:0]         dvsr;  // divisor magnitude, up to 2^15
  } div_t;

  // per-item record carried alongside the divider
  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] res;      // final result unless a divide is in flight
    logic [1:0]         st;
    logic               div_neg;  // quotient sign
    logic               div_fast; // divide already resolved (zero or overflow)
  } tag_t;

endpackage

// File: rtl/core/q15au_div_stage.sv
// ----------------------------------------------------------------------------
// q15au_div_stage: one register stage of the restoring divider
// Works STEPS quotient bits per cycle on unsigned magnitudes.
// ----------------------------------------------------------------------------
module q15au_div_stage #(
  parameter int STEPS = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid_in,
  input  q15au_pkg::div_t  div_in,
  output logic             valid_out,
  output q15au_pkg::div_t  div_out
);

  q15au_pkg::div_t div_next;

  // shift-compare-subtract, STEPS bits deep
  always_comb begin
    logic [16:0] shifted;
    div_next = div_in;
    for (int i = 0; i < STEPS; i++) begin
      shifted = {div_next.rem, 1'b0};
      if (shifted >= {1'b0, div_next.dvsr}) begin
        div_next.rem = 16'(shifted - {1'b0, div_next.dvsr});
        div_next.quo = {div_next.quo[q15au_pkg::DIV_BITS-2:0], 1'b1};
      end else begin
        div_next.rem = shifted[15:0];
        div_next.quo = {div_next.quo[q15au_pkg::DIV_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    div_out <= div_next;
  end

endmodule

// File: rtl/core/q15_arith_unit_top.sv
// ----------------------------------------------------------------------------
// q15_arith_unit_top: pipelined signed Q15 arithmetic unit
// Saturating add, multiply with arithmetic shift, and divide through a
// five-stage restoring divider. One item may enter every cycle.
//
//  Channel  | Handshake     | Fields
//  ---------+---------------+----------------------------------
//  input    | start / busy  | command, operand_a, operand_b
//  output   | done (strobe) | result, status
//
// Every item passes, from acceptance to its done strobe, through the input
// register, the operand/product stage, five divider stages of three quotient
// bits each, and the output register. Throughput is one item per cycle.
// Reset clears all valid bits; busy is high only during reset.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module q15_arith_unit_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic signed [15:0] operand_a,
  input  logic signed [15:0] operand_b,
  output logic               done,
  output logic signed [15:0] result,
  output logic [1:0]         status
);

  localparam int NSTG = q15au_pkg::DIV_STAGES;

  logic accept;

  // input register
  logic               v1;
  logic [1:0]         cmd1;
  logic signed [15:0] a1;
  logic signed [15:0] b1;

  // operand stage
  logic               v2;
  q15au_pkg::tag_t    tag2, tag2_next;
  q15au_pkg::div_t    div2, div2_next;
  logic signed [31:0] prod2;

  // divider stages
  logic            vd   [NSTG+1];
  q15au_pkg::div_t dd   [NSTG+1];
  q15au_pkg::tag_t tagd [NSTG+1];
  q15au_pkg::tag_t tag_mul;

  assign busy   = rst;
  assign accept = start && !busy;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    cmd1 <= command;
    a1   <= operand_a;
    b1   <= operand_b;
  end

  // add result, divide set-up and special divide cases
  always_comb begin
    logic signed [16:0] sum;
    logic [15:0]        ma;
    logic [15:0]        mb;
    logic               neg;
    sum = {a1[15], a1} + {b1[15], b1};
    ma  = a1[15] ? 16'(-a1) : a1;
    mb  = b1[15] ? 16'(-b1) : b1;
    neg = a1[15] ^ b1[15];

    tag2_next          = '0;
    tag2_next.cmd      = cmd1;
    tag2_next.div_neg  = neg;
    tag2_next.res      = '0;
    tag2_next.st       = q15au_pkg::ST_OK;
    tag2_next.div_fast = 1'b0;

    div2_next.rem  = ma;
    div2_next.quo  = '0;
    div2_next.dvsr = mb;

    case (cmd1)
      q15au_pkg::CMD_ADD: begin
        if (sum > 17'(q15au_pkg::Q15_MAX)) begin
          tag2_next.res = q15au_pkg::Q15_MAX;
          tag2_next.st  = q15au_pkg::ST_SAT;
        end else if (sum < 17'(q15au_pkg::Q15_SYM_MIN)) begin
          tag2_next.res = q15au_pkg::Q15_SYM_MIN;
          tag2_next.st  = q15au_pkg::ST_SAT;
        end else begin
          tag2_next.res = sum[15:0];
        end
      end
      q15au_pkg::CMD_DIV: begin
        if (b1 == 16'sd0) begin
          tag2_next.div_fast = 1'b1;
          tag2_next.res = a1[15] ? q15au_pkg::Q15_SYM_MIN : q15au_pkg::Q15_MAX;
          tag2_next.st  = q15au_pkg::ST_DIVZ;
        end else if (ma >= mb) begin
          // quotient magnitude reaches 2^15; only -1.0 exactly fits
          tag2_next.div_fast = 1'b1;
          if (neg && ma == mb) begin
            tag2_next.res = q15au_pkg::Q15_MIN;
            tag2_next.st  = q15au_pkg::ST_OK;
          end else begin
            tag2_next.res = neg ? q15au_pkg::Q15_SYM_MIN : q15au_pkg::Q15_MAX;
            tag2_next.st  = q15au_pkg::ST_SAT;
          end
        end
      end
      default: begin
        tag2_next.res = '0;
        tag2_next.st  = q15au_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    tag2  <= tag2_next;
    div2  <= div2_next;
    prod2 <= a1 * b1;
  end

  // multiply finish: floor shift by 15, -1.0 x -1.0 saturates
  always_comb begin
    tag_mul = tag2;
    if (tag2.cmd == q15au_pkg::CMD_MUL) begin
      if (prod2 == 32'sh4000_0000) begin
        tag_mul.res = q15au_pkg::Q15_MAX;
        tag_mul.st  = q15au_pkg::ST_SAT;
      end else begin
        tag_mul.res = prod2[30:15];
        tag_mul.st  = q15au_pkg::ST_OK;
      end
    end
  end

  assign vd[0]   = v2;
  assign dd[0]   = div2;
  assign tagd[0] = tag_mul;

  // divider pipeline, the record rides alongside
  for (genvar g = 0; g < NSTG; g++) begin : g_div
    q15au_div_stage #(
      .STEPS (q15au_pkg::STEPS_PER_STAGE)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (vd[g]),
      .div_in    (dd[g]),
      .valid_out (vd[g+1]),
      .div_out   (dd[g+1])
    );

    always_ff @(posedge clk) begin
      tagd[g+1] <= tagd[g];
    end
  end

  // output register: apply quotient sign
  q15au_pkg::tag_t tag_last;
  logic [15:0]     quo_ext;
  logic signed [15:0] result_next;
  logic [1:0]         status_next;

  assign tag_last = tagd[NSTG];
  assign quo_ext  = {1'b0, dd[NSTG].quo};

  always_comb begin
    result_next = tag_last.res;
    status_next = tag_last.st;
    if (tag_last.cmd == q15au_pkg::CMD_DIV && !tag_last.div_fast) begin
      result_next = tag_last.div_neg ? 16'(-quo_ext) : quo_ext;
      status_next = q15au_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vd[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    status <= status_next;
  end

  // every accepted item leaves with exactly one done strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done == $past(accept, 8))
    else $error("done strobe does not match accepted item");

  // the divider remainder must stay below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (vd[NSTG] && tag_last.cmd == q15au_pkg::CMD_DIV && !tag_last.div_fast)
      |-> (dd[NSTG].rem < dd[NSTG].dvsr))
    else $error("divider remainder out of range");

  // a saturated result sits on one of the symmetric limits
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (done && status == q15au_pkg::ST_SAT)
      |-> (result == q15au_pkg::Q15_MAX || result == q15au_pkg::Q15_SYM_MIN))
    else $error("saturated result off the limits");

endmodule
